// ===== sv/dat_pkg.sv =====
package dat_pkg;

	localparam int KIND_W    = 3;
	localparam int SESSION_W = 5;
	localparam int PAYLOAD_W = 48;
	localparam int RELOAD_W  = 12;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_RELOAD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE     = 1'b1;

	localparam logic [RELOAD_W-1:0] RELOAD_RESET   = 12'd313;
	localparam logic [KIND_W-1:0]   ACK_TYPE_RESET = 3'd2;

	// command codes
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef struct packed {
		logic                 command;
		logic [KIND_W-1:0]    event_kind;
		logic [SESSION_W-1:0] session_index;
		logic [PAYLOAD_W-1:0] event_payload;
		logic                 downstream_full;
	} item_t;

	typedef struct packed {
		logic                 forward_valid;
		logic [KIND_W-1:0]    out_kind;
		logic [SESSION_W-1:0] out_session;
		logic [PAYLOAD_W-1:0] out_payload;
		logic                 rx_signal;
		logic                 tx_signal;
	} res_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} clr_state_t;

endpackage

// ===== sv/dat_ram.sv =====
module dat_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/dat_ptr.sv =====
module dat_ptr import dat_pkg::*; #(
	parameter int SESSION_COUNT = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick_accept,
	output logic                             clearing,
	output logic [$clog2(SESSION_COUNT)-1:0] clr_addr,
	output logic [$clog2(SESSION_COUNT)-1:0] scan_ptr
);

	localparam int AW = $clog2(SESSION_COUNT);
	localparam logic [AW-1:0] LAST = AW'(SESSION_COUNT - 1);

	clr_state_t      state_q, state_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic [AW-1:0]   ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	// clearing pass walks the table once after reset
	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		case (state_q)
			ST_CLEAR: begin
				clr_d = clr_q + AW'(1);
				if (clr_q == LAST) begin
					state_d = ST_RUN;
					clr_d   = '0;
				end
			end
			ST_RUN: begin
				state_d = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (tick_accept) begin
			ptr_q <= (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
		end
	end

	assign clearing = (state_q == ST_CLEAR);
	assign clr_addr = clr_q;
	assign scan_ptr = ptr_q;

endmodule

// ===== sv/delayed_ack_timer_table_core.sv =====
// path: an accepted item is registered in stage 1, then its result in the output register
// throughput: one item per cycle unless the output stalls, set by the single counter
//   ram read-modify-write; a same-entry access in the next cycle is served by forwarding
// reset: asynchronous, active low; after reset a clearing pass zeroes all SESSION_COUNT
//   counter ram entries, during which no item is accepted (config writes still are)
module delayed_ack_timer_table_core import dat_pkg::*; #(
	parameter int SESSION_COUNT = 32,
	parameter int COUNTER_BITS  = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  item_t                in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output res_t                 out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RELOAD_W-1:0]  cfg_data
);

	localparam int AW = $clog2(SESSION_COUNT);
	localparam int CB = COUNTER_BITS;

	// configuration
	logic [RELOAD_W-1:0] reload_q;
	logic [KIND_W-1:0]   ack_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RESET;
			ack_q    <= ACK_TYPE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DELAY_RELOAD: reload_q <= cfg_data;
				REG_ACK_TYPE:     ack_q    <= cfg_data[KIND_W-1:0];
				default:          ;
			endcase
		end
	end

	logic [CB+RELOAD_W-1:0] reload_wide;
	logic [CB-1:0]          reload_cnt;
	assign reload_wide = {{CB{1'b0}}, reload_q};
	assign reload_cnt  = reload_wide[CB-1:0];

	// clearing pass and scan pointer
	logic          clearing;
	logic [AW-1:0] clr_addr;
	logic [AW-1:0] scan_ptr;
	logic          accept;

	assign accept = in_valid && in_ready;

	dat_ptr #(
		.SESSION_COUNT(SESSION_COUNT)
	) u_ptr (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_accept (accept && (in_item.command == CMD_TICK)),
		.clearing    (clearing),
		.clr_addr    (clr_addr),
		.scan_ptr    (scan_ptr)
	);

	// read side at acceptance
	logic [AW+SESSION_W-1:0] ev_addr_wide;
	logic [AW-1:0]           rd_addr;
	logic                    ev_in_table;

	assign ev_addr_wide = {{AW{1'b0}}, in_item.session_index};
	assign rd_addr      = (in_item.command == CMD_TICK) ? scan_ptr : ev_addr_wide[AW-1:0];
	assign ev_in_table  = 32'(in_item.session_index) < 32'(SESSION_COUNT);

	// ram ports
	logic          we;
	logic [AW-1:0] waddr;
	logic [CB-1:0] wdata;
	logic [CB-1:0] rdata;

	dat_ram #(
		.WIDTH (CB),
		.DEPTH (SESSION_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// stage 1 registers
	logic          vld_s1;
	item_t         item_s1;
	logic [AW-1:0] addr_s1;
	logic          in_table_s1;
	logic          fwd_s1;
	logic [CB-1:0] fwd_data_s1;

	// stage 1 update
	logic          s1_we;
	logic [CB-1:0] s1_wdata;
	logic          has_res;
	res_t          res;
	logic [CB-1:0] cnt;
	logic          advance;
	logic          slot_free;
	logic [AW+SESSION_W-1:0] sess_wide;

	assign cnt       = fwd_s1 ? fwd_data_s1 : rdata;
	assign sess_wide = {{SESSION_W{1'b0}}, addr_s1};

	always_comb begin
		s1_we    = 1'b0;
		s1_wdata = '0;
		has_res  = 1'b0;
		res      = '0;
		if (item_s1.command == CMD_EVENT) begin
			has_res       = 1'b1;
			res.rx_signal = 1'b1;
			if (in_table_s1 && item_s1.event_kind == ack_q && cnt == '0) begin
				// first ack of the session is held back
				s1_we    = 1'b1;
				s1_wdata = reload_cnt;
			end else begin
				s1_we             = in_table_s1;
				res.forward_valid = 1'b1;
				res.out_kind      = item_s1.event_kind;
				res.out_session   = item_s1.session_index;
				res.out_payload   = item_s1.event_payload;
				res.tx_signal     = 1'b1;
			end
		end else if (cnt != '0 && !item_s1.downstream_full) begin
			s1_we    = 1'b1;
			s1_wdata = cnt - CB'(1);
			if (cnt == CB'(1)) begin
				// timer expiry, generate the ack
				has_res           = 1'b1;
				res.forward_valid = 1'b1;
				res.out_kind      = ack_q;
				res.out_session   = sess_wide[SESSION_W-1:0];
				res.tx_signal     = 1'b1;
			end
		end
	end

	logic  out_valid_q;
	res_t  out_item_q;

	assign slot_free = !out_valid_q || out_ready;
	assign advance   = vld_s1 && (!has_res || slot_free);
	assign in_ready  = !clearing && (!vld_s1 || advance);

	always_comb begin
		if (clearing) begin
			we    = 1'b1;
			waddr = clr_addr;
			wdata = '0;
		end else begin
			we    = advance && s1_we;
			waddr = addr_s1;
			wdata = s1_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			addr_s1     <= rd_addr;
			in_table_s1 <= (in_item.command == CMD_TICK) || ev_in_table;
			// same entry written this cycle, ram read is stale
			fwd_s1      <= we && (waddr == rd_addr);
			fwd_data_s1 <= wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("item accepted during clearing pass");

	a_held_ack_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rx_signal && !out_item.tx_signal
		|-> !out_item.forward_valid && out_item.out_payload == '0)
		else $error("held-back ack carries forward data");

	a_gen_ack_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.rx_signal
		|-> out_item.tx_signal && out_item.out_kind == ack_q && out_item.out_payload == '0)
		else $error("generated ack malformed");

	a_stall_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |-> !we)
		else $error("counter written while stage 1 stalled");
`endif

endmodule
